[design/gtmc_pkg.sv]
// Package for the growing-tree maze carver: item structs, event and direction codes,
// and the control word that is broadcast along the path-cell chain. No dependencies.
package gtmc_pkg;

   localparam int GTMC_MAX_SIDE = 16;
   localparam int GTMC_SIDE_LIMIT = 64;
   localparam int CTL_IDX_W = 12;
   localparam int CTL_ENTRY_W = 12;
   localparam int RAW_W = 15;

   typedef enum logic [1:0] {
      EV_STARTED = 2'd0,
      EV_CARVED = 2'd1,
      EV_RETIRED = 2'd2,
      EV_DONE = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      DIR_LEFT = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_TOP = 2'd2,
      DIR_BOTTOM = 2'd3
   } dir_type;

   localparam logic FUNC_START = 1'b0;

   typedef struct packed {
      logic func;
      logic coin;
      logic [RAW_W-1:0] random_index;
      logic [RAW_W-1:0] random_neighbor;
      logic [RAW_W-1:0] start_x_raw;
      logic [RAW_W-1:0] start_y_raw;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [1:0] direction;
      logic [8:0] path_length;
   } rsp_type;

   typedef struct packed {
      logic wr;
      logic rm;
      logic [CTL_IDX_W-1:0] idx;
      logic [CTL_ENTRY_W-1:0] data;
   } cell_ctl_type;

endpackage

[design/growing_tree_maze_carver_top.sv]
// Top level of the growing-tree maze carver: control sequencer, visited map and
// the chain of path cells. Uses gtmc_pkg, gtmc_path_cell and gtmc_divider.
//
// Usage:
//  - Issue an item by raising start with req_data while busy is low; it is taken
//    at that clock edge. A start item (func 0) begins a new maze, a step item
//    (func 1) carves one wall or retires one path cell.
//  - Each item yields exactly one result on rsp_data, marked by rsp_valid for one
//    cycle. There is no backpressure: catch the result when rsp_valid is high.
//  - Write maze_side through csr_valid/csr_data (csr_ready is always high) while
//    the block is idle; the value is latched into the active side at the next start.
// Sequencing:
//  - Start item: two remainder passes, x then y, on the shared divider; the
//    result is registered as the block returns to idle and busy drops with it.
//  - Step item with a random entry: index pass, read, scan, neighbor pass; a retire
//    ends after the scan, with no neighbor pass. A newest-entry step skips the
//    index pass.
//  - Step on an empty path: result in the cycle after acceptance, busy stays low.
//  - The serial divider sets the rate; the path chain shifts all its entries at once.
// Reset: the visited map clears, the path is empty, maze_side returns to 16.
module growing_tree_maze_carver_top import gtmc_pkg::*; #(
   parameter int MAX_SIDE = GTMC_MAX_SIDE
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [4:0] csr_data
);
   localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int CNTW = $clog2(CELLS + 1);
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int DW = (CNTW > SW) ? CNTW : SW;

   typedef enum logic [2:0] {
      S_IDLE, S_SX, S_SY, S_IDX, S_READ, S_NB, S_PICK
   } state_type;

   state_type state_ff;
   req_type req_ff;
   logic [4:0] maze_side_ff;
   logic [SW-1:0] side_ff;
   logic [SW-1:0] side_clamped;
   logic [MAX_SIDE-1:0] visited_ff [MAX_SIDE];
   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] pos_ff;
   logic [CW-1:0] sx_ff, x_ff, y_ff;
   logic [3:0] flags_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic div_go, div_done;
   logic [RAW_W-1:0] div_num;
   logic [DW-1:0] div_den, div_rem;
   cell_ctl_type ctl;
   logic [CTL_ENTRY_W-1:0] cell_data [CELLS];
   logic [CTL_ENTRY_W-1:0] cell_rd [CELLS];
   logic [CTL_ENTRY_W-1:0] rd_bus;
   logic accept;
   logic [3:0] flags;
   logic [2:0] n_open;
   logic [1:0] pick_dir;
   logic [CW-1:0] nx, ny;
   logic [CW-1:0] sy_now;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Clamp the written side into 2..MAX_SIDE.
   always_comb begin
      if (maze_side_ff < 5'd2) begin
         side_clamped = SW'(2);
      end else if (int'(maze_side_ff) > MAX_SIDE) begin
         side_clamped = SW'(MAX_SIDE);
      end else begin
         side_clamped = SW'(maze_side_ff);
      end
   end

   // Open neighbors of the current cell, in order left, right, top, bottom.
   always_comb begin
      flags[0] = (x_ff != '0) && !visited_ff[y_ff][x_ff - 1'b1];
      flags[1] = ((SW + 1)'(x_ff) + 1'b1 < (SW + 1)'(side_ff)) && !visited_ff[y_ff][x_ff + 1'b1];
      flags[2] = (y_ff != '0) && !visited_ff[y_ff - 1'b1][x_ff];
      flags[3] = ((SW + 1)'(y_ff) + 1'b1 < (SW + 1)'(side_ff)) && !visited_ff[y_ff + 1'b1][x_ff];
      n_open = 3'(flags[0]) + 3'(flags[1]) + 3'(flags[2]) + 3'(flags[3]);
   end

   // Select the k-th open direction, k being the divider's remainder.
   always_comb begin
      logic [2:0] seen;
      seen = '0;
      pick_dir = DIR_LEFT;
      for (int d = 0; d < 4; d++) begin
         if (flags_ff[d]) begin
            if (seen == {1'b0, div_rem[1:0]}) begin
               pick_dir = 2'(d);
            end
            seen = seen + 1'b1;
         end
      end
      nx = x_ff;
      ny = y_ff;
      unique case (pick_dir)
         DIR_LEFT: nx = x_ff - 1'b1;
         DIR_RIGHT: nx = x_ff + 1'b1;
         DIR_TOP: ny = y_ff - 1'b1;
         DIR_BOTTOM: ny = y_ff + 1'b1;
         default: nx = x_ff;
      endcase
   end

   assign sy_now = CW'(div_rem);

   // Divider requests and chain control.
   always_comb begin
      div_go = 1'b0;
      div_num = req_data.start_x_raw;
      div_den = DW'(side_clamped);
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.func == FUNC_START) begin
               div_go = 1'b1;
            end else if (accept && count_ff != '0 && req_data.coin) begin
               div_go = 1'b1;
               div_num = req_data.random_index;
               div_den = DW'(count_ff);
            end
         end
         S_SX: begin
            div_num = req_ff.start_y_raw;
            div_den = DW'(side_ff);
            div_go = div_done;
         end
         S_SY: begin
            ctl.wr = div_done;
            ctl.idx = '0;
            ctl.data = CTL_ENTRY_W'({sy_now, sx_ff});
         end
         S_IDX: ctl = '0;
         S_READ: ctl.idx = CTL_IDX_W'(pos_ff);
         S_NB: begin
            div_num = req_ff.random_neighbor;
            div_den = DW'(n_open);
            div_go = (n_open != '0);
            ctl.rm = (n_open == '0);
            ctl.idx = CTL_IDX_W'(pos_ff);
         end
         S_PICK: begin
            ctl.wr = div_done && (int'(count_ff) < CELLS);
            ctl.idx = CTL_IDX_W'(count_ff);
            ctl.data = CTL_ENTRY_W'({ny, nx});
         end
         default: ctl = '0;
      endcase
   end

   gtmc_divider #(.DW(DW)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(div_num),
      .divisor(div_den), .done(div_done), .rem(div_rem)
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      gtmc_path_cell #(.IDX(i)) u_cell (
         .clock(clock), .ctl(ctl),
         .nb_data((i == CELLS - 1) ? cell_data[i] : cell_data[(i + 1) % CELLS]),
         .data(cell_data[i]), .rd_data(cell_rd[i])
      );
   end

   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < CELLS; i++) begin
         rd_bus = rd_bus | cell_rd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         maze_side_ff <= 5'd16;
         side_ff <= SW'(MAX_SIDE);
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_SIDE; r++) begin
            visited_ff[r] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            maze_side_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  if (req_data.func == FUNC_START) begin
                     side_ff <= side_clamped;
                     for (int r = 0; r < MAX_SIDE; r++) begin
                        visited_ff[r] <= '0;
                     end
                     state_ff <= S_SX;
                  end else if (count_ff == '0) begin
                     // Empty path: report done at once.
                     rsp_ff <= '{EV_DONE, 4'd0, 4'd0, DIR_LEFT, 9'd0};
                     rsp_valid_ff <= 1'b1;
                  end else if (req_data.coin) begin
                     state_ff <= S_IDX;
                  end else begin
                     pos_ff <= count_ff - 1'b1;
                     state_ff <= S_READ;
                  end
               end
            end
            S_SX: begin
               if (div_done) begin
                  sx_ff <= CW'(div_rem);
                  state_ff <= S_SY;
               end
            end
            S_SY: begin
               if (div_done) begin
                  visited_ff[sy_now][sx_ff] <= 1'b1;
                  count_ff <= CNTW'(1);
                  rsp_ff <= '{EV_STARTED, 4'(sx_ff), 4'(sy_now), DIR_LEFT, 9'd1};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_IDX: begin
               if (div_done) begin
                  pos_ff <= CNTW'(div_rem);
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               x_ff <= rd_bus[CW-1:0];
               y_ff <= rd_bus[2*CW-1:CW];
               state_ff <= S_NB;
            end
            S_NB: begin
               flags_ff <= flags;
               if (n_open == '0) begin
                  // Retire: the chain closes the gap in this same cycle.
                  count_ff <= count_ff - 1'b1;
                  rsp_ff <= '{EV_RETIRED, 4'(x_ff), 4'(y_ff), DIR_LEFT,
                              9'(count_ff - 1'b1)};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               if (div_done) begin
                  visited_ff[ny][nx] <= 1'b1;
                  if (int'(count_ff) < CELLS) begin
                     count_ff <= count_ff + 1'b1;
                     rsp_ff <= '{EV_CARVED, 4'(x_ff), 4'(y_ff), pick_dir,
                                 9'(count_ff + 1'b1)};
                  end else begin
                     rsp_ff <= '{EV_CARVED, 4'(x_ff), 4'(y_ff), pick_dir, 9'(count_ff)};
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CELLS)
      else $error("path count exceeds cell count");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.func == FUNC_START |=> busy)
      else $error("start item did not occupy the block");
   a_carve_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res == EV_CARVED |-> count_ff != '0)
      else $error("carve reported with empty path");
`endif
endmodule

[design/gtmc_path_cell.sv]
// One cell of the path chain: holds one path entry, loads it by index, takes its
// right neighbor's entry on a removal at or below its place. Uses gtmc_pkg.
module gtmc_path_cell import gtmc_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic clock,
   input  cell_ctl_type ctl,
   input  logic [CTL_ENTRY_W-1:0] nb_data,
   output logic [CTL_ENTRY_W-1:0] data,
   output logic [CTL_ENTRY_W-1:0] rd_data
);
   localparam logic [CTL_IDX_W-1:0] MY_IDX = CTL_IDX_W'(IDX);

   logic [CTL_ENTRY_W-1:0] entry_ff;
   logic [CTL_ENTRY_W-1:0] entry_in;
   logic hit;

   assign hit = (ctl.idx == MY_IDX);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr && hit) begin
         entry_in = ctl.data;
      end else if (ctl.rm && (MY_IDX >= ctl.idx)) begin
         entry_in = nb_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;
   // Drive the read bus only from the addressed cell.
   assign rd_data = hit ? entry_ff : '0;
endmodule

[design/gtmc_divider.sv]
// Restoring remainder unit: one quotient bit per cycle over a 15-bit dividend.
// Uses gtmc_pkg for the dividend width.
module gtmc_divider import gtmc_pkg::*; #(
   parameter int DW = 9
) (
   input  logic clock,
   input  logic reset,
   input  logic go,
   input  logic [RAW_W-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic done,
   output logic [DW-1:0] rem
);
   localparam int CNT_W = $clog2(RAW_W + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [RAW_W-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic run_ff, done_ff;
   logic [DW:0] trial;

   always_comb begin
      trial = {rem_ff, num_ff[RAW_W-1]};
      if (trial >= {1'b0, den_ff}) begin
         trial = trial - {1'b0, den_ff};
      end
      rem_in = trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RAW_W - 1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= '0;
         num_ff <= dividend;
         den_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[RAW_W-2:0], 1'b0};
      end
   end

   assign done = done_ff;
   assign rem = rem_ff;
endmodule
